// ===== rtl/lagw_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lagw_pkg
// Shared types and constants of the lattice aggregation walker step block.
// ----------------------------------------------------------------------------
package lagw_pkg;

    // register indexes of the configuration port
    localparam logic [1:0] CFG_END_COUNT   = 2'd0;
    localparam logic [1:0] CFG_STICK_THRES = 2'd1;
    localparam logic [1:0] CFG_ADD_RATIO   = 2'd2;
    localparam logic [1:0] CFG_KILL_RATIO  = 2'd3;

    // integer square root unit: operand is dist2 << 16, below 2^28
    localparam int SQ_W    = 28;
    localparam int SQ_ITER = 14;
    localparam int ROOT_W  = 14;

    typedef enum logic [2:0] {
        EV_SPAWNED  = 3'd0,
        EV_BLOCKED  = 3'd1,
        EV_MOVED    = 3'd2,
        EV_STUCK    = 3'd3,
        EV_REMOVED  = 3'd4,
        EV_REJECTED = 3'd5,
        EV_FINISHED = 3'd6,
        EV_HALTED   = 3'd7
    } ev_t;

    typedef enum logic [4:0] {
        ST_CLEAR,
        ST_CENTRE,
        ST_IDLE,
        ST_EVAL,
        ST_SPAWN_CHK,
        ST_KILL,
        ST_TGT_CHK,
        ST_MOVE_SET,
        ST_NB_RD,
        ST_NB_CHK,
        ST_STICK,
        ST_SQRT_WAIT,
        ST_GROW1,
        ST_GROW2,
        ST_GROW3,
        ST_GROW4,
        ST_DONE
    } state_t;

    typedef enum logic [1:0] {
        MEM_IDLE,
        MEM_READ,
        MEM_WRITE
    } mem_op_t;

    typedef enum logic [2:0] {
        A_CLEAR,
        A_CENTRE,
        A_WALKER,
        A_TARGET,
        A_SPAWN,
        A_NB
    } addr_sel_t;

    typedef struct packed {
        logic      latch;
        mem_op_t   mem_op;
        addr_sel_t asel;
        logic      wbit;
        logic      calc;
        logic      set_event;
        ev_t       ev;
        logic      spawn_take;
        logic      kill_take;
        logic      move_take;
        logic      stick_clr;
        logic      nb_acc;
        logic      deact;
        logic      sqrt_start;
        logic      grow1;
        logic      grow2;
        logic      grow3;
        logic      grow4;
        logic      out_load;
        logic      clr_step;
    } cmd_t;

    typedef struct packed {
        logic clear_last;
        logic halted;
        logic active;
        logic count_lt_end;
        logic spawn_in_grid;
        logic kill;
        logic tgt_in_grid;
        logic rd_bit;
        logic nb_last;
        logic stick;
        logic sqrt_done;
        logic rr_gt_cluster;
        logic spawn_lt_need;
        logic out_free;
    } sts_t;

endpackage

// ===== rtl/lattice_aggregation_walker_step.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lattice_aggregation_walker_step
// One step of three-dimensional diffusion-limited aggregation per request.
// ----------------------------------------------------------------------------
// After reset the block sweeps its occupancy memory, one cell a cycle, and
// accepts no request in that time; configuration writes are taken at any
// time. Requests are then handled one at a time by a sequencer around a
// single-port occupancy memory: a plain move takes a target read, two
// writes and six neighbour reads, and a move that sticks adds the
// 14-iteration square root and the radius update. The result of a step
// waits in an output register while the next request is taken.
module lattice_aggregation_walker_step
    import lagw_pkg::*;
#(
    parameter int GRID_SIDE = 64
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // hop_dir, draw_px, draw_nx, draw_py, draw_ny, draw_pz, draw_nz,
    // spawn_x, spawn_y, spawn_z
    input  logic [87:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // walker_x, walker_y, walker_z, particle_count, cluster_radius_out,
    // spawn_radius_out, stop_flag
    output logic [71:0] m_tdata,
    // event_res
    output logic [2:0]  m_tuser,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    cmd_t cmd;
    sts_t sts;

    assign cfg_ready = 1'b1;

    lagw_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    lagw_datapath #(
        .GRID_SIDE (GRID_SIDE)
    ) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .sts       (sts),
        .in_data   (s_tdata),
        .cfg_we    (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

endmodule

// ===== rtl/lagw_isqrt.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lagw_isqrt
// Iterative integer square root, two operand bits per cycle.
// ----------------------------------------------------------------------------
module lagw_isqrt
    import lagw_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              start,
    input  logic [SQ_W-1:0]   operand,
    output logic              done,
    output logic [ROOT_W-1:0] root
);

    localparam int CW = $clog2(SQ_ITER + 1);

    logic [SQ_W-1:0] v_reg, v_next;
    logic [SQ_W-1:0] r_reg, r_next;
    logic [SQ_W-1:0] bit_reg, bit_next;
    logic [CW-1:0]   cnt_reg, cnt_next;
    logic            busy_reg, busy_next;
    logic [SQ_W:0]   trial;

    always_comb begin
        v_next    = v_reg;
        r_next    = r_reg;
        bit_next  = bit_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        trial     = {1'b0, r_reg} + {1'b0, bit_reg};
        if (start) begin
            v_next    = operand;
            r_next    = '0;
            bit_next  = SQ_W'(1) << (2 * SQ_ITER - 2);
            cnt_next  = '0;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if ({1'b0, v_reg} >= trial) begin
                v_next = SQ_W'({1'b0, v_reg} - trial);
                r_next = (r_reg >> 1) + bit_reg;
            end else begin
                r_next = r_reg >> 1;
            end
            bit_next = bit_reg >> 2;
            cnt_next = cnt_reg + CW'(1);
            if (cnt_reg == CW'(SQ_ITER - 1)) begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
        v_reg   <= v_next;
        r_reg   <= r_next;
        bit_reg <= bit_next;
    end

    assign done = !busy_reg;
    assign root = r_reg[ROOT_W-1:0];

endmodule

// ===== rtl/lagw_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lagw_datapath
// Occupancy memory, walker and radius state, arithmetic and output register.
// ----------------------------------------------------------------------------
module lagw_datapath
    import lagw_pkg::*;
#(
    parameter int GRID_SIDE = 64
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  cmd_t        cmd,
    output sts_t        sts,
    input  logic [87:0] in_data,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [71:0] m_tdata,
    output logic [2:0]  m_tuser
);

    localparam int S     = GRID_SIDE;
    localparam int HALF  = GRID_SIDE / 2;
    localparam int CELLS = GRID_SIDE * GRID_SIDE * GRID_SIDE;
    localparam int AW    = $clog2(CELLS);
    localparam int LO    = (HALF > 32) ? -32 : -HALF;
    localparam int HI    = (GRID_SIDE - HALF - 1 > 31) ? 31 : GRID_SIDE - HALF - 1;
    localparam logic [16:0] STOP_LVL = 17'(HALF * 256);

    function automatic logic in_grid(input logic signed [6:0] c);
        return (int'(c) >= LO) && (int'(c) <= HI);
    endfunction

    function automatic logic [AW-1:0] addr_of(input logic signed [6:0] x,
                                              input logic signed [6:0] y,
                                              input logic signed [6:0] z);
        int xi, yi, zi;
        xi = int'(x) + HALF;
        yi = int'(y) + HALF;
        zi = int'(z) + HALF;
        return AW'(xi * S * S + yi * S + zi);
    endfunction

    function automatic logic [11:0] dist2(input logic signed [6:0] x,
                                          input logic signed [6:0] y,
                                          input logic signed [6:0] z);
        int s;
        s = int'(x) * int'(x) + int'(y) * int'(y) + int'(z) * int'(z);
        return 12'(s);
    endfunction

    // configuration
    logic [15:0] end_count_reg;
    logic [9:0]  stick_thres_reg;
    logic [9:0]  add_ratio_reg;
    logic [9:0]  kill_ratio_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            end_count_reg   <= 16'd10;
            stick_thres_reg <= 10'd1000;
            add_ratio_reg   <= 10'd307;
            kill_ratio_reg  <= 10'd435;
        end else if (cfg_we) begin
            case (cfg_index)
                CFG_END_COUNT:   end_count_reg   <= cfg_data;
                CFG_STICK_THRES: stick_thres_reg <= cfg_data[9:0];
                CFG_ADD_RATIO:   add_ratio_reg   <= cfg_data[9:0];
                CFG_KILL_RATIO:  kill_ratio_reg  <= cfg_data[9:0];
                default: ;
            endcase
        end
    end

    // latched request
    logic [87:0] req_reg;
    logic [2:0]  hop_dir;
    logic signed [6:0] sp_x, sp_y, sp_z;

    always_ff @(posedge aclk) begin
        if (cmd.latch) begin
            req_reg <= in_data;
        end
    end

    assign hop_dir = req_reg[2:0];
    assign sp_x    = 7'(signed'(req_reg[68:63]));
    assign sp_y    = 7'(signed'(req_reg[74:69]));
    assign sp_z    = 7'(signed'(req_reg[80:75]));

    // walker and block state
    logic [17:0] walker_reg;
    logic        active_reg;
    logic [15:0] count_reg;
    logic [15:0] cluster_reg;
    logic [15:0] spawn_reg;
    logic [15:0] kill_reg;
    logic        halted_reg;
    ev_t         ev_reg;
    logic signed [6:0] wx, wy, wz;

    assign wx = 7'(signed'(walker_reg[5:0]));
    assign wy = 7'(signed'(walker_reg[11:6]));
    assign wz = 7'(signed'(walker_reg[17:12]));

    // hop target and kill test operands
    logic signed [6:0] tx_reg, ty_reg, tz_reg;
    logic signed [6:0] tx, ty, tz;
    logic [11:0] td2_reg;
    logic [31:0] kill_sq_reg;

    always_comb begin
        tx = wx;
        ty = wy;
        tz = wz;
        case (hop_dir)
            3'd0: tx = wx + 7'sd1;
            3'd1: tx = wx - 7'sd1;
            3'd2: ty = wy + 7'sd1;
            3'd3: ty = wy - 7'sd1;
            3'd4: tz = wz + 7'sd1;
            3'd5: tz = wz - 7'sd1;
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (cmd.calc) begin
            tx_reg      <= tx;
            ty_reg      <= ty;
            tz_reg      <= tz;
            td2_reg     <= dist2(tx, ty, tz);
            kill_sq_reg <= kill_reg * kill_reg;
        end
    end

    // neighbour scan
    logic [2:0] nb_idx_reg;
    logic       nb_valid_reg;
    logic       stick_reg;
    logic signed [6:0] nx, ny, nz;
    logic [9:0] draw;

    always_comb begin
        nx = wx;
        ny = wy;
        nz = wz;
        draw = req_reg[12:3];
        case (nb_idx_reg)
            3'd0: begin nx = wx + 7'sd1; draw = req_reg[12:3];  end
            3'd1: begin nx = wx - 7'sd1; draw = req_reg[22:13]; end
            3'd2: begin ny = wy + 7'sd1; draw = req_reg[32:23]; end
            3'd3: begin ny = wy - 7'sd1; draw = req_reg[42:33]; end
            3'd4: begin nz = wz + 7'sd1; draw = req_reg[52:43]; end
            3'd5: begin nz = wz - 7'sd1; draw = req_reg[62:53]; end
            default: ;
        endcase
    end

    // occupancy memory
    logic          mem [CELLS];
    logic          rd_reg;
    logic [AW-1:0] clr_cnt_reg;
    logic [AW-1:0] addr;
    logic          nb_ok;

    assign nb_ok = in_grid(nx) && in_grid(ny) && in_grid(nz);

    always_comb begin
        case (cmd.asel)
            A_CLEAR:  addr = clr_cnt_reg;
            A_CENTRE: addr = addr_of(7'sd0, 7'sd0, 7'sd0);
            A_WALKER: addr = addr_of(wx, wy, wz);
            A_TARGET: addr = addr_of(tx_reg, ty_reg, tz_reg);
            A_SPAWN:  addr = addr_of(sp_x, sp_y, sp_z);
            A_NB:     addr = nb_ok ? addr_of(nx, ny, nz) : '0;
            default:  addr = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (cmd.mem_op == MEM_WRITE) begin
            mem[addr] <= cmd.wbit;
        end
        if (cmd.mem_op == MEM_READ) begin
            rd_reg       <= mem[addr];
            nb_valid_reg <= nb_ok;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_cnt_reg <= '0;
        end else if (cmd.clr_step) begin
            clr_cnt_reg <= clr_cnt_reg + AW'(1);
        end
    end

    // square root of the stuck distance
    logic              sq_done;
    logic [ROOT_W-1:0] sq_root;
    logic [15:0]       rr;

    lagw_isqrt u_isqrt (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cmd.sqrt_start),
        .operand ({dist2(wx, wy, wz), 16'd0}),
        .done    (sq_done),
        .root    (sq_root)
    );

    assign rr = 16'(sq_root);

    // radius growth
    logic [25:0] need_prod_reg;
    logic [25:0] kill_prod_reg;
    logic [17:0] need_raw, need_max;
    logic [16:0] need_min;
    logic [15:0] need;
    logic [16:0] kill_sum;

    always_comb begin
        need_raw = need_prod_reg[25:8];
        need_min = {1'b0, cluster_reg} + 17'd1280;
        need_max = (need_raw < 18'(need_min)) ? 18'(need_min) : need_raw;
        need     = (need_max > 18'hFFFF) ? 16'hFFFF : need_max[15:0];
        kill_sum = {1'b0, kill_reg} + 17'd512;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            walker_reg  <= '0;
            active_reg  <= 1'b0;
            count_reg   <= 16'd1;
            cluster_reg <= '0;
            spawn_reg   <= 16'd2560;
            kill_reg    <= 16'd5120;
            halted_reg  <= 1'b0;
            ev_reg      <= EV_SPAWNED;
            nb_idx_reg  <= '0;
            stick_reg   <= 1'b0;
        end else begin
            if (cmd.set_event) begin
                ev_reg <= cmd.ev;
            end
            if (cmd.spawn_take) begin
                walker_reg <= req_reg[80:63];
                active_reg <= 1'b1;
                count_reg  <= count_reg + 16'd1;
            end
            if (cmd.kill_take) begin
                active_reg <= 1'b0;
                if (count_reg != 16'd0) begin
                    count_reg <= count_reg - 16'd1;
                end
            end
            if (cmd.move_take) begin
                walker_reg <= {tz_reg[5:0], ty_reg[5:0], tx_reg[5:0]};
            end
            if (cmd.stick_clr) begin
                nb_idx_reg <= '0;
                stick_reg  <= 1'b0;
            end
            if (cmd.nb_acc) begin
                nb_idx_reg <= nb_idx_reg + 3'd1;
                if (rd_reg && nb_valid_reg && (draw < stick_thres_reg)) begin
                    stick_reg <= 1'b1;
                end
            end
            if (cmd.deact) begin
                active_reg <= 1'b0;
            end
            if (cmd.grow1) begin
                cluster_reg <= rr;
            end
            if (cmd.grow2 && (spawn_reg < need)) begin
                spawn_reg <= need;
            end
            if (cmd.grow3) begin
                kill_reg <= (kill_prod_reg[25:8] > 18'hFFFF) ? 16'hFFFF
                                                             : kill_prod_reg[23:8];
            end
            if (cmd.grow4 && (kill_sum >= STOP_LVL)) begin
                halted_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.grow1) begin
            need_prod_reg <= rr * add_ratio_reg;
        end
        if (cmd.grow2) begin
            kill_prod_reg <= need * kill_ratio_reg;
        end
    end

    // output register
    logic        m_valid_reg;
    logic [71:0] m_data_reg;
    logic [2:0]  m_user_reg;
    logic [17:0] out_pos;

    assign out_pos = (ev_reg == EV_BLOCKED) ? req_reg[80:63] : walker_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
        if (cmd.out_load) begin
            m_data_reg <= {5'd0, halted_reg, spawn_reg, cluster_reg, count_reg, out_pos};
            m_user_reg <= ev_reg;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;

    // status
    always_comb begin
        sts.clear_last    = (clr_cnt_reg == AW'(CELLS - 1));
        sts.halted        = halted_reg;
        sts.active        = active_reg;
        sts.count_lt_end  = (count_reg < end_count_reg);
        sts.spawn_in_grid = in_grid(sp_x) && in_grid(sp_y) && in_grid(sp_z);
        sts.kill          = ({4'd0, td2_reg, 16'd0} > kill_sq_reg);
        sts.tgt_in_grid   = in_grid(tx_reg) && in_grid(ty_reg) && in_grid(tz_reg);
        sts.rd_bit        = rd_reg;
        sts.nb_last       = (nb_idx_reg == 3'd5);
        sts.stick         = stick_reg;
        sts.sqrt_done     = sq_done;
        sts.rr_gt_cluster = (rr > cluster_reg);
        sts.spawn_lt_need = (spawn_reg < need);
        sts.out_free      = !m_valid_reg || m_tready;
    end

endmodule

// ===== rtl/lagw_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lagw_ctrl
// Sequencer of the memory clear after reset and of one step: memory accesses, neighbour scan and radius growth.
// ----------------------------------------------------------------------------
module lagw_ctrl
    import lagw_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic s_tvalid,
    output logic s_tready,
    input  sts_t sts,
    output cmd_t cmd
);

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:     if (sts.clear_last) state_next = ST_CENTRE;
            ST_CENTRE:    state_next = ST_IDLE;
            ST_IDLE:      if (s_tvalid) state_next = ST_EVAL;
            ST_EVAL: begin
                if (sts.halted) state_next = ST_DONE;
                else if (sts.active) state_next = ST_KILL;
                else if (sts.count_lt_end && sts.spawn_in_grid) state_next = ST_SPAWN_CHK;
                else state_next = ST_DONE;
            end
            ST_SPAWN_CHK: state_next = ST_DONE;
            ST_KILL: begin
                if (sts.kill || !sts.tgt_in_grid) state_next = ST_DONE;
                else state_next = ST_TGT_CHK;
            end
            ST_TGT_CHK:   state_next = sts.rd_bit ? ST_DONE : ST_MOVE_SET;
            ST_MOVE_SET:  state_next = ST_NB_RD;
            ST_NB_RD:     state_next = ST_NB_CHK;
            ST_NB_CHK:    state_next = sts.nb_last ? ST_STICK : ST_NB_RD;
            ST_STICK:     state_next = sts.stick ? ST_SQRT_WAIT : ST_DONE;
            ST_SQRT_WAIT: if (sts.sqrt_done) state_next = ST_GROW1;
            ST_GROW1:     state_next = sts.rr_gt_cluster ? ST_GROW2 : ST_DONE;
            ST_GROW2:     state_next = sts.spawn_lt_need ? ST_GROW3 : ST_GROW4;
            ST_GROW3:     state_next = ST_GROW4;
            ST_GROW4:     state_next = ST_DONE;
            ST_DONE:      if (sts.out_free) state_next = ST_IDLE;
            default:      state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        cmd      = '0;
        s_tready = 1'b0;
        case (state_reg)
            ST_CLEAR: begin
                cmd.mem_op   = MEM_WRITE;
                cmd.asel     = A_CLEAR;
                cmd.clr_step = 1'b1;
            end
            ST_CENTRE: begin
                cmd.mem_op = MEM_WRITE;
                cmd.asel   = A_CENTRE;
                cmd.wbit   = 1'b1;
            end
            ST_IDLE: begin
                s_tready  = 1'b1;
                cmd.latch = s_tvalid;
            end
            ST_EVAL: begin
                cmd.calc = 1'b1;
                if (sts.halted) begin
                    cmd.set_event = 1'b1;
                    cmd.ev        = EV_HALTED;
                end else if (sts.active) begin
                    cmd.set_event = 1'b0;
                end else if (sts.count_lt_end) begin
                    if (sts.spawn_in_grid) begin
                        cmd.mem_op = MEM_READ;
                        cmd.asel   = A_SPAWN;
                    end else begin
                        cmd.set_event = 1'b1;
                        cmd.ev        = EV_BLOCKED;
                    end
                end else begin
                    cmd.set_event = 1'b1;
                    cmd.ev        = EV_FINISHED;
                end
            end
            ST_SPAWN_CHK: begin
                cmd.set_event = 1'b1;
                if (sts.rd_bit) begin
                    cmd.ev = EV_BLOCKED;
                end else begin
                    cmd.ev         = EV_SPAWNED;
                    cmd.mem_op     = MEM_WRITE;
                    cmd.asel       = A_SPAWN;
                    cmd.wbit       = 1'b1;
                    cmd.spawn_take = 1'b1;
                end
            end
            ST_KILL: begin
                if (sts.kill) begin
                    cmd.mem_op    = MEM_WRITE;
                    cmd.asel      = A_WALKER;
                    cmd.kill_take = 1'b1;
                    cmd.set_event = 1'b1;
                    cmd.ev        = EV_REMOVED;
                end else if (!sts.tgt_in_grid) begin
                    cmd.set_event = 1'b1;
                    cmd.ev        = EV_REJECTED;
                end else begin
                    cmd.mem_op = MEM_READ;
                    cmd.asel   = A_TARGET;
                end
            end
            ST_TGT_CHK: begin
                if (sts.rd_bit) begin
                    cmd.set_event = 1'b1;
                    cmd.ev        = EV_REJECTED;
                end else begin
                    cmd.mem_op = MEM_WRITE;
                    cmd.asel   = A_WALKER;
                end
            end
            ST_MOVE_SET: begin
                cmd.mem_op    = MEM_WRITE;
                cmd.asel      = A_TARGET;
                cmd.wbit      = 1'b1;
                cmd.move_take = 1'b1;
                cmd.stick_clr = 1'b1;
            end
            ST_NB_RD: begin
                cmd.mem_op = MEM_READ;
                cmd.asel   = A_NB;
            end
            ST_NB_CHK: begin
                cmd.asel   = A_NB;
                cmd.nb_acc = 1'b1;
            end
            ST_STICK: begin
                cmd.set_event = 1'b1;
                if (sts.stick) begin
                    cmd.ev         = EV_STUCK;
                    cmd.deact      = 1'b1;
                    cmd.sqrt_start = 1'b1;
                end else begin
                    cmd.ev = EV_MOVED;
                end
            end
            ST_GROW1: cmd.grow1 = sts.rr_gt_cluster;
            ST_GROW2: cmd.grow2 = 1'b1;
            ST_GROW3: cmd.grow3 = 1'b1;
            ST_GROW4: cmd.grow4 = 1'b1;
            ST_DONE:  cmd.out_load = sts.out_free;
            default: ;
        endcase
    end

endmodule
